>>> hw/rtl/bts_pkg.sv
`default_nettype none

package bts_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   typedef logic [1:0] axis_type;

   // control from the sequencer to the energy unit
   typedef struct packed {
      logic     save_sq;
      logic     save_lo;
      logic     write;
      axis_type axis;
   } en_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/ball_throw_slide_step.sv
// channel   | valid      | stall      | payload
// ----------+------------+------------+--------------------------------------------
// request   | req_valid  | req_stall  | req_command, req_start_*, req_launch_v*,
//           |            |            | req_friction
// response  | rsp_valid  | rsp_stall  | rsp_out_*, rsp_out_v*, rsp_energy_*, rsp_moving
// csr       | csr_we     | -          | csr_index, csr_wdata
//
// one request at a time; a launch or a stopped ball goes straight to the energies,
// a tick on a moving ball runs the enabled throw step, then the enabled slide step.
// each of the three energies runs the square, low, high and accumulate states on the
// single 33x33 multiplier; the throw step adds its multiply, gravity and air states.
// sync active-high reset clears sequencer, ball state, csrs (mass to one).
// req_stall is high from acceptance until the response is taken; a stalled
// response holds its value.

`default_nettype none

module ball_throw_slide_step import bts_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_command,
   input  wire logic signed [31:0] req_start_x,
   input  wire logic signed [31:0] req_start_y,
   input  wire logic signed [31:0] req_start_z,
   input  wire logic signed [31:0] req_launch_vx,
   input  wire logic signed [31:0] req_launch_vy,
   input  wire logic signed [31:0] req_launch_vz,
   input  wire logic [30:0]        req_friction,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic signed [31:0]      rsp_out_vx,
   output logic signed [31:0]      rsp_out_vy,
   output logic signed [31:0]      rsp_out_vz,
   output logic [47:0]             rsp_energy_x,
   output logic [47:0]             rsp_energy_y,
   output logic [47:0]             rsp_energy_z,
   output logic                    rsp_moving,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);

   localparam int TICK_INT = ((1 << FRAC_BITS) + 30) / 60;
   localparam logic signed [31:0] TICK_TIME = 32'(TICK_INT);
   localparam logic [30:0] MASS_ONE = 31'(64'd1 << FRAC_BITS);

   localparam logic [2:0] REG_GRAVITY = 3'd0;
   localparam logic [2:0] REG_AIR     = 3'd1;
   localparam logic [2:0] REG_MASS    = 3'd2;
   localparam logic [2:0] REG_THROW   = 3'd3;
   localparam logic [2:0] REG_SLIDE   = 3'd4;

   localparam logic CMD_LAUNCH = 1'b0;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_TH_MUL = 4'd1;
   localparam logic [3:0] ST_TH_GRV = 4'd2;
   localparam logic [3:0] ST_TH_AIR = 4'd3;
   localparam logic [3:0] ST_SLIDE  = 4'd4;
   localparam logic [3:0] ST_EN_SQ  = 4'd5;
   localparam logic [3:0] ST_EN_LO  = 4'd6;
   localparam logic [3:0] ST_EN_HI  = 4'd7;
   localparam logic [3:0] ST_EN_ACC = 4'd8;
   localparam logic [3:0] ST_OUT    = 4'd9;

   localparam axis_type AXIS_LAST = 2'd2;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
      logic signed [31:0] r;
      if (s[32] != s[31]) begin
         r = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = s[31:0];
      end
      return r;
   endfunction

   logic [3:0]          state_ff, state_in;
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  pos_in [3];
   logic signed [31:0]  vel_ff [3];
   logic signed [31:0]  vel_in [3];
   logic signed [31:0]  elapsed_ff, elapsed_in;
   logic                moving_ff, moving_in;
   logic [30:0]         friction_ff, friction_in;
   axis_type            axis_ff, axis_in;
   logic signed [31:0]  gravity_ff, gravity_in;
   logic [30:0]         air_ff, air_in;
   logic [30:0]         mass_ff, mass_in;
   logic                throw_en_ff, throw_en_in;
   logic                slide_en_ff, slide_en_in;

   logic                   accept;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   logic [31:0]            sq_hi;
   logic [31:0]            vel_abs;
   logic signed [32:0]     vel_neg;
   logic signed [PROD_W-1:0] grav_shift;
   logic signed [31:0]     grav_term;
   logic signed [31:0]     elapsed_step;
   logic signed [31:0]     air_s;
   logic signed [31:0]     fric_s;
   en_ctl_type             en_ctl;

   // shared multiplier and energy unit
   bts_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   bts_energy #(
      .FRAC_BITS (FRAC_BITS)
   ) u_energy (
      .clock    (clock),
      .ctl      (en_ctl),
      .prod     (prod[63:0]),
      .sq_hi_ff (sq_hi),
      .energy_x (rsp_energy_x),
      .energy_y (rsp_energy_y),
      .energy_z (rsp_energy_z)
   );

   // handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);

   // common terms
   always_comb begin
      vel_neg      = -{vel_ff[axis_ff][31], vel_ff[axis_ff]};
      vel_abs      = vel_ff[axis_ff][31] ? vel_neg[31:0] : vel_ff[axis_ff];
      grav_shift   = prod >>> FRAC_BITS;
      if ((&grav_shift[PROD_W-1:31]) || !(|grav_shift[PROD_W-1:31])) begin
         grav_term = grav_shift[31:0];
      end else begin
         grav_term = grav_shift[PROD_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      elapsed_step = sat32({elapsed_ff[31], elapsed_ff} + {TICK_TIME[31], TICK_TIME});
      air_s        = $signed({1'b0, air_ff});
      fric_s       = $signed({1'b0, friction_ff});
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_TH_MUL: begin
            mul_a = {gravity_ff[31], gravity_ff};
            mul_b = {elapsed_ff[31], elapsed_ff};
         end
         ST_EN_SQ: begin
            mul_a = {1'b0, vel_abs};
            mul_b = {1'b0, vel_abs};
         end
         ST_EN_LO: begin
            mul_a = {2'b0, mass_ff};
            mul_b = {1'b0, prod[31:0]};
         end
         ST_EN_HI: begin
            mul_a = {2'b0, mass_ff};
            mul_b = {1'b0, sq_hi};
         end
         default: begin
         end
      endcase
   end

   // energy unit control
   always_comb begin
      en_ctl.save_sq = (state_ff == ST_EN_LO);
      en_ctl.save_lo = (state_ff == ST_EN_HI);
      en_ctl.write   = (state_ff == ST_EN_ACC);
      en_ctl.axis    = axis_ff;
   end

   // configuration writes
   always_comb begin
      gravity_in  = gravity_ff;
      air_in      = air_ff;
      mass_in     = mass_ff;
      throw_en_in = throw_en_ff;
      slide_en_in = slide_en_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRAVITY: gravity_in  = csr_wdata;
            REG_AIR:     air_in      = csr_wdata[30:0];
            REG_MASS:    mass_in     = csr_wdata[30:0];
            REG_THROW:   throw_en_in = csr_wdata[0];
            REG_SLIDE:   slide_en_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and motion datapath
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      vel_in      = vel_ff;
      elapsed_in  = elapsed_ff;
      moving_in   = moving_ff;
      friction_in = friction_ff;
      axis_in     = axis_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               friction_in = req_friction;
               axis_in     = '0;
               if (req_command == CMD_LAUNCH) begin
                  pos_in[0]  = req_start_x;
                  pos_in[1]  = req_start_y;
                  pos_in[2]  = req_start_z;
                  vel_in[0]  = req_launch_vx;
                  vel_in[1]  = req_launch_vy;
                  vel_in[2]  = req_launch_vz;
                  elapsed_in = '0;
                  moving_in  = 1'b1;
                  state_in   = ST_EN_SQ;
               end else if (moving_ff && throw_en_ff) begin
                  state_in = ST_TH_MUL;
               end else if (moving_ff && slide_en_ff) begin
                  state_in = ST_SLIDE;
               end else begin
                  state_in = ST_EN_SQ;
               end
            end
         end
         ST_TH_MUL: begin
            state_in = ST_TH_GRV;
         end
         // move, then add the gravity term to vy
         ST_TH_GRV: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i] = sat32({pos_ff[i][31], pos_ff[i]} + {vel_ff[i][31], vel_ff[i]});
            end
            vel_in[1] = sat32({vel_ff[1][31], vel_ff[1]} + {grav_term[31], grav_term});
            state_in  = ST_TH_AIR;
         end
         // air resistance, vy kept when not above it
         ST_TH_AIR: begin
            for (int i = 0; i < 3; i++) begin
               if (vel_ff[i] > air_s) begin
                  vel_in[i] = vel_ff[i] - air_s;
               end else if (i != 1) begin
                  vel_in[i] = '0;
               end
            end
            elapsed_in = elapsed_step;
            state_in   = slide_en_ff ? ST_SLIDE : ST_EN_SQ;
         end
         // move, then friction toward zero
         ST_SLIDE: begin
            for (int i = 0; i < 3; i++) begin
               pos_in[i] = sat32({pos_ff[i][31], pos_ff[i]} + {vel_ff[i][31], vel_ff[i]});
               if ((vel_ff[i] > fric_s) || (vel_ff[i] < -fric_s)) begin
                  vel_in[i] = (vel_ff[i] > 0) ? vel_ff[i] - fric_s : vel_ff[i] + fric_s;
               end else begin
                  vel_in[i] = '0;
               end
            end
            elapsed_in = elapsed_step;
            state_in   = ST_EN_SQ;
         end
         ST_EN_SQ: begin
            state_in = ST_EN_LO;
         end
         ST_EN_LO: begin
            state_in = ST_EN_HI;
         end
         ST_EN_HI: begin
            state_in = ST_EN_ACC;
         end
         ST_EN_ACC: begin
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_EN_SQ;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pos_ff      <= '{default: '0};
         vel_ff      <= '{default: '0};
         elapsed_ff  <= '0;
         moving_ff   <= 1'b0;
         axis_ff     <= '0;
         gravity_ff  <= '0;
         air_ff      <= '0;
         mass_ff     <= MASS_ONE;
         throw_en_ff <= 1'b0;
         slide_en_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_ff      <= pos_in;
         vel_ff      <= vel_in;
         elapsed_ff  <= elapsed_in;
         moving_ff   <= moving_in;
         axis_ff     <= axis_in;
         gravity_ff  <= gravity_in;
         air_ff      <= air_in;
         mass_ff     <= mass_in;
         throw_en_ff <= throw_en_in;
         slide_en_ff <= slide_en_in;
      end
      friction_ff <= friction_in;
   end

   // response payload
   assign rsp_out_x  = pos_ff[0];
   assign rsp_out_y  = pos_ff[1];
   assign rsp_out_z  = pos_ff[2];
   assign rsp_out_vx = vel_ff[0];
   assign rsp_out_vy = vel_ff[1];
   assign rsp_out_vz = vel_ff[2];
   assign rsp_moving = moving_ff;

`ifndef SYNTHESIS
   // no new request while a response is pending
   a_busy_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a response is pending");

   // a taken response frees the block next cycle
   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> (!rsp_valid && !req_stall))
      else $error("response repeated after hand-off");

   // once moving, the ball stays moving until reset
   a_moving_sticky: assert property (@(posedge clock) disable iff (reset)
      moving_ff |=> moving_ff)
      else $error("moving flag cleared");

   // elapsed time never goes negative
   a_elapsed_pos: assert property (@(posedge clock) disable iff (reset)
      !elapsed_ff[31])
      else $error("elapsed time negative");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/bts_mul.sv
`default_nettype none

module bts_mul import bts_pkg::*; (
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  mul_a,
   input  wire logic signed [MUL_W-1:0]  mul_b,
   output logic signed [PROD_W-1:0]      prod_ff
);

   logic signed [PROD_W-1:0] prod_in;

   // one signed product per cycle, registered
   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

>>> hw/rtl/bts_energy.sv
`default_nettype none

module bts_energy import bts_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire en_ctl_type  ctl,
   input  wire logic [63:0] prod,
   output logic [31:0]      sq_hi_ff,
   output logic [47:0]      energy_x,
   output logic [47:0]      energy_y,
   output logic [47:0]      energy_z
);

   localparam int SHIFT  = 2 * FRAC_BITS + 1;
   localparam int WIDE_W = 95;

   logic [62:0]       lo_ff;
   logic [47:0]       en_ff [3];
   logic [WIDE_W-1:0] wide_sum;
   logic [WIDE_W-1:0] shifted;
   logic [47:0]       energy_in;

   // mass*v^2 = mass*hi*2^32 + mass*lo, then scale down and saturate
   always_comb begin
      wide_sum  = {prod[62:0], 32'b0} + {32'b0, lo_ff};
      shifted   = wide_sum >> SHIFT;
      energy_in = (|shifted[WIDE_W-1:48]) ? '1 : shifted[47:0];
   end

   // partial products and per-axis results
   always_ff @(posedge clock) begin
      if (ctl.save_sq) begin
         sq_hi_ff <= prod[63:32];
      end
      if (ctl.save_lo) begin
         lo_ff <= prod[62:0];
      end
      if (ctl.write) begin
         en_ff[ctl.axis] <= energy_in;
      end
   end

   assign energy_x = en_ff[0];
   assign energy_y = en_ff[1];
   assign energy_z = en_ff[2];

endmodule

`default_nettype wire

>>> tb/sv/tb_ball_throw_slide_step.sv
`default_nettype none

module tb_ball_throw_slide_step;

   // register map and command codes
   localparam logic [2:0] REG_GRAVITY     = 3'd0;
   localparam logic [2:0] REG_AIR_DRAG    = 3'd1;
   localparam logic [2:0] REG_MASS        = 3'd2;
   localparam logic [2:0] REG_THROW_EN    = 3'd3;
   localparam logic [2:0] REG_SLIDE_EN    = 3'd4;
   localparam logic       CMD_LAUNCH      = 1'b0;
   localparam logic       CMD_TICK        = 1'b1;

   localparam int    FRAC          = 16;
   localparam longint ONE_Q        = longint'(1) << FRAC;
   localparam longint TICK_STEP    = (ONE_Q + 30) / 60;
   localparam longint S32_HI       = 64'sd2147483647;
   localparam longint S32_LO       = -64'sd2147483648;
   localparam int    HOLD_CYCLES   = 300;
   localparam int    STALL_LIMIT   = 3000;
   localparam int    DRAIN_CYCLES  = 24;
   localparam int    RANDOM_PHASES = 8;
   localparam int    PHASE_ITEMS   = 150;

   typedef struct packed {
      logic        command;
      logic [31:0] sx, sy, sz;
      logic [31:0] vx, vy, vz;
      logic [30:0] friction;
   } ball_req_type;

   typedef struct packed {
      logic [31:0] px, py, pz;
      logic [31:0] vx, vy, vz;
      logic [47:0] ex, ey, ez;
      logic        moving;
   } ball_state_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // block ports
   logic              req_valid = 1'b0;
   wire logic         req_stall;
   ball_req_type      req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic signed [31:0] rsp_out_vx, rsp_out_vy, rsp_out_vz;
   logic [47:0]       rsp_energy_x, rsp_energy_y, rsp_energy_z;
   logic              rsp_moving;
   logic              csr_we = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [31:0]       csr_wdata = '0;

   ball_throw_slide_step u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_item.command),
      .req_start_x   (req_item.sx),
      .req_start_y   (req_item.sy),
      .req_start_z   (req_item.sz),
      .req_launch_vx (req_item.vx),
      .req_launch_vy (req_item.vy),
      .req_launch_vz (req_item.vz),
      .req_friction  (req_item.friction),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_vx    (rsp_out_vx),
      .rsp_out_vy    (rsp_out_vy),
      .rsp_out_vz    (rsp_out_vz),
      .rsp_energy_x  (rsp_energy_x),
      .rsp_energy_y  (rsp_energy_y),
      .rsp_energy_z  (rsp_energy_z),
      .rsp_moving    (rsp_moving),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // shadow registers and ball state
   longint grav = 0;
   longint air_drag = 0;
   longint ball_mass = ONE_Q;
   bit     throw_on = 1'b0;
   bit     slide_on = 1'b0;
   longint ball_pos [3] = '{0, 0, 0};
   longint ball_vel [3] = '{0, 0, 0};
   longint ball_time = 0;
   bit     ball_moving = 1'b0;

   ball_req_type   req_backlog [$];
   ball_state_type ball_results_due [$];
   int          in_flight = 0;
   int          fault_count = 0;
   int          launch_count = 0;
   int          tick_count = 0;
   int          config_writes = 0;
   bit          idling = 1'b1;
   bit          hold_armed = 1'b0;
   bit          req_done = 1'b0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   function automatic longint sat32(longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
   endfunction

   // half m v^2, saturated to 48 bits
   function automatic logic [47:0] kinetic_energy(longint v);
      logic [127:0] mag;
      logic [127:0] prod;
      mag = (v < 0) ? -v : v;
      prod = (mag * mag * ball_mass) >> (2 * FRAC + 1);
      if (prod > 128'hFFFF_FFFF_FFFF) return 48'hFFFF_FFFF_FFFF;
      return prod[47:0];
   endfunction

   function automatic void drift_position();
      for (int i = 0; i < 3; i++) ball_pos[i] = sat32(ball_pos[i] + ball_vel[i]);
   endfunction

   // next ball state for one accepted request
   function automatic ball_state_type advance_ball(ball_req_type it);
      ball_state_type r;
      longint fr;
      fr = longint'(it.friction);
      if (it.command == CMD_LAUNCH) begin
         ball_pos[0] = $signed(it.sx);
         ball_pos[1] = $signed(it.sy);
         ball_pos[2] = $signed(it.sz);
         ball_vel[0] = $signed(it.vx);
         ball_vel[1] = $signed(it.vy);
         ball_vel[2] = $signed(it.vz);
         ball_time = 0;
         ball_moving = 1'b1;
      end else if (ball_moving) begin
         // throw: move, gravity from the time before this step, then air drag
         if (throw_on) begin
            drift_position();
            ball_vel[1] = sat32(ball_vel[1] + sat32((grav * ball_time) >>> FRAC));
            for (int i = 0; i < 3; i++) begin
               if (ball_vel[i] > air_drag) ball_vel[i] -= air_drag;
               else if (i != 1) ball_vel[i] = 0;
            end
            ball_time = sat32(ball_time + TICK_STEP);
         end
         // slide: move, then friction pulls each axis toward zero
         if (slide_on) begin
            drift_position();
            for (int i = 0; i < 3; i++) begin
               if (ball_vel[i] > fr) ball_vel[i] -= fr;
               else if (-ball_vel[i] > fr) ball_vel[i] += fr;
               else ball_vel[i] = 0;
            end
            ball_time = sat32(ball_time + TICK_STEP);
         end
      end
      r.px = ball_pos[0][31:0];
      r.py = ball_pos[1][31:0];
      r.pz = ball_pos[2][31:0];
      r.vx = ball_vel[0][31:0];
      r.vy = ball_vel[1][31:0];
      r.vz = ball_vel[2][31:0];
      r.ex = kinetic_energy(ball_vel[0]);
      r.ey = kinetic_energy(ball_vel[1]);
      r.ez = kinetic_energy(ball_vel[2]);
      r.moving = ball_moving;
      return r;
   endfunction

   task automatic check_field(input string fname, input logic [47:0] got,
                              input logic [47:0] want);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("mismatch on %s: expected %h, got %h", fname, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (req_valid && idling && $urandom_range(0, 3) == 0)
            send_gap = $urandom_range(1, 18);
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_item <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: one long hold-off when armed, random bursts otherwise
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_armed && rsp_valid) begin
         hold_armed = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // request acceptance and prediction
   always @(posedge clock) begin
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            ball_results_due.push_back(advance_ball(req_item));
            if (req_item.command == CMD_LAUNCH) launch_count++;
            else tick_count++;
         end
      end
   end

   // response checking
   always @(posedge clock) begin
      ball_state_type seen;
      ball_state_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.px = rsp_out_x;
         seen.py = rsp_out_y;
         seen.pz = rsp_out_z;
         seen.vx = rsp_out_vx;
         seen.vy = rsp_out_vy;
         seen.vz = rsp_out_vz;
         seen.ex = rsp_energy_x;
         seen.ey = rsp_energy_y;
         seen.ez = rsp_energy_z;
         seen.moving = rsp_moving;
         if (ball_results_due.size() == 0) begin
            fault_count++;
            if (fault_count <= 10) $display("response with nothing outstanding");
         end else begin
            due = ball_results_due.pop_front();
            in_flight--;
            check_field("out_x", seen.px, due.px);
            check_field("out_y", seen.py, due.py);
            check_field("out_z", seen.pz, due.pz);
            check_field("out_vx", seen.vx, due.vx);
            check_field("out_vy", seen.vy, due.vy);
            check_field("out_vz", seen.vz, due.vz);
            check_field("energy_x", seen.ex, due.ex);
            check_field("energy_y", seen.ey, due.ey);
            check_field("energy_z", seen.ez, due.ez);
            check_field("moving", seen.moving, due.moving);
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus helpers
   function automatic void add_launch(logic [31:0] x, y, z, v_x, v_y, v_z);
      ball_req_type it;
      it.command = CMD_LAUNCH;
      it.sx = x;
      it.sy = y;
      it.sz = z;
      it.vx = v_x;
      it.vy = v_y;
      it.vz = v_z;
      it.friction = 31'($urandom);
      req_backlog.push_back(it);
      in_flight++;
   endfunction

   function automatic void add_tick(logic [30:0] fr);
      ball_req_type it;
      it.command = CMD_TICK;
      {it.sx, it.sy, it.sz} = {$urandom, $urandom, $urandom};
      {it.vx, it.vy, it.vz} = {$urandom, $urandom, $urandom};
      it.friction = fr;
      req_backlog.push_back(it);
      in_flight++;
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 7))
         0: w = 32'h7FFF_FFFF;
         1: w = 32'h8000_0000;
         2, 3: w = $urandom;
         default: begin
            w = $urandom_range(0, 32'h0020_0000);
            if ($urandom_range(0, 1)) w = -w;
         end
      endcase
      return w;
   endfunction

   function automatic logic [30:0] pick_friction();
      case ($urandom_range(0, 5))
         0: return 31'd0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 32'h0004_0000));
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      config_writes++;
      case (idx)
         REG_GRAVITY:  grav = $signed(data);
         REG_AIR_DRAG: air_drag = longint'(data[30:0]);
         REG_MASS:     ball_mass = longint'(data[30:0]);
         REG_THROW_EN: throw_on = data[0];
         REG_SLIDE_EN: slide_on = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] g, a, m, input logic t, s);
      logic [31:0] t_word;
      logic [31:0] s_word;
      t_word = $urandom;
      s_word = $urandom;
      t_word[0] = t;
      s_word[0] = s;
      write_reg(REG_GRAVITY, g);
      write_reg(REG_AIR_DRAG, a);
      write_reg(REG_MASS, m);
      write_reg(REG_THROW_EN, t_word);
      write_reg(REG_SLIDE_EN, s_word);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (in_flight != 0) @(negedge clock);
   endtask

   // random throws: mostly a launch followed by a run of ticks, some stray requests
   task automatic random_phase(input int n_items);
      int made;
      int run;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            add_launch(pick_word(), pick_word(), pick_word(),
                       pick_word(), pick_word(), pick_word());
            run = $urandom_range(1, 24);
            for (int k = 0; k < run; k++) add_tick(pick_friction());
            made += run + 1;
         end else begin
            if ($urandom_range(0, 1))
               add_tick(pick_friction());
            else
               add_launch(pick_word(), pick_word(), pick_word(),
                          pick_word(), pick_word(), pick_word());
            made++;
         end
      end
   endtask

   function automatic logic [31:0] pick_gravity();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom;
         default: return $urandom_range(0, 32'h0000_2000) - 32'h0000_1000;
      endcase
   endfunction

   function automatic logic [31:0] pick_drag();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return $urandom;
         default: return $urandom_range(0, 32'h0000_4000);
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h0001_0000;
         2: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // main sequence
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);

      // reset values: a tick on a resting ball, then a launch at the range limits and a tick
      add_tick(31'h7FFF_FFFF);
      add_launch(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      add_tick(31'd0);
      wait_idle();

      // both steps, strongest downward gravity, heaviest ball
      set_config(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
      add_launch(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_tick(31'd0);
      add_tick(31'd0);
      add_launch(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      add_tick(31'h7FFF_FFFF);
      add_tick(31'd0);
      add_launch(32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000,
                 32'h0000_8000, 32'hFFFD_8000, 32'h0002_0000);
      add_tick(31'h0000_8000);
      add_tick(31'h0000_8000);
      add_tick(31'h7FFF_FFFF);
      wait_idle();

      // throw only, strongest upward gravity, drag at full scale, massless
      set_config(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b0);
      add_launch(32'd0, 32'd0, 32'd0, 32'h0005_0000, 32'h0005_0000, 32'hFFFB_0000);
      add_tick(31'h5555_5555);
      add_tick(31'h2AAA_AAAA);
      add_tick(31'd0);
      wait_idle();

      // slide only, unit mass, small drag that the slide step ignores
      set_config(32'hFFFF_0000, 32'h0000_4000, 32'h0001_0000, 1'b0, 1'b1);
      add_launch(32'h0010_0000, 32'hFFF0_0000, 32'd0,
                 32'h0000_3000, 32'hFFFF_D000, 32'h0000_1000);
      add_tick(31'h0000_1000);
      add_tick(31'h0000_1000);
      add_tick(31'h0000_1000);
      wait_idle();

      // random part; every pairing of the two step enables comes up twice
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(pick_gravity(), pick_drag(), pick_mass(), ph[0], ph[1]);
         idling = !(ph == 3 || ph == RANDOM_PHASES - 1);
         if (ph == 2) hold_armed = 1'b1;
         random_phase(PHASE_ITEMS);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d launches and %0d ticks over %0d register writes",
               launch_count, tick_count, config_writes);
      $display("all four step-enable pairings, saturating limits and a long response hold-off");
      if (fault_count == 0 && ball_results_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures, %0d responses outstanding", fault_count,
                  ball_results_due.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
